// File: src/afbp_pkg.sv
// ----------------------------------------------------------------------------
// afbp_pkg
// Types and constants shared by the flash byte programmer modules.
// ----------------------------------------------------------------------------
package afbp_pkg;

  typedef enum logic [2:0] {
    PH_WAIT_START,
    PH_GET_BASE,
    PH_GET_ADDR,
    PH_GET_LEN,
    PH_WAIT_DATA,
    PH_POLL,
    PH_HALT
  } phase_t;

  typedef enum logic [2:0] {
    RUN_NONE,
    RUN_ACK,
    RUN_ACK_FIN,
    RUN_FIN,
    RUN_PROGRAM,
    RUN_READ,
    RUN_FAIL
  } run_kind_t;

  typedef struct packed {
    run_kind_t   kind;
    logic [31:0] base;
    logic [31:0] addr;
    logic [7:0]  data;
  } run_desc_t;

  localparam logic [1:0] OP_WRITE = 2'd0;
  localparam logic [1:0] OP_READ  = 2'd1;
  localparam logic [1:0] OP_SEND  = 2'd2;

  localparam logic [31:0] OFS_UNLOCK1 = 32'h0000_0555;
  localparam logic [31:0] OFS_UNLOCK2 = 32'h0000_02AA;

  localparam logic [7:0] CMD_UNLOCK1 = 8'hAA;
  localparam logic [7:0] CMD_UNLOCK2 = 8'h55;
  localparam logic [7:0] CMD_PROGRAM = 8'hA0;
  localparam logic [7:0] CMD_RESET   = 8'hF0;

  localparam logic [31:0] TOK_START = 32'h4D52_4140;
  localparam logic [31:0] TOK_ACK   = 32'h216b_6361;
  localparam logic [31:0] TOK_FIN   = 32'h216e_6966;
  localparam logic [31:0] TOK_NACK  = 32'h6b63_614e;

  localparam logic [1:0] LAST_BYTE = 2'd3;

endpackage

// File: src/afbp_in_if.sv
// ----------------------------------------------------------------------------
// afbp_in_if
// Input channel: link words and flash read bytes with a valid/ready handshake.
// ----------------------------------------------------------------------------
interface afbp_in_if;
  logic        valid;
  logic        ready;
  logic        cmd;
  logic [31:0] link_word;
  logic [7:0]  flash_byte;

  modport source (output valid, cmd, link_word, flash_byte, input ready);
  modport sink (input valid, cmd, link_word, flash_byte, output ready);
endinterface

// File: src/afbp_out_if.sv
// ----------------------------------------------------------------------------
// afbp_out_if
// Output channel: flash bus operations and link replies with valid/ready.
// ----------------------------------------------------------------------------
interface afbp_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  op_kind;
  logic [31:0] bus_address;
  logic [31:0] bus_data;
  logic        last_of_run;

  modport source (output valid, op_kind, bus_address, bus_data, last_of_run, input ready);
  modport sink (input valid, op_kind, bus_address, bus_data, last_of_run, output ready);
endinterface

// File: src/amd_flash_byte_programmer_top.sv
// ----------------------------------------------------------------------------
// amd_flash_byte_programmer_top
// Flash byte programmer with data polling, driven by debug link words.
//
// The item channel carries either a debug link word (cmd 0) or a byte read
// back from flash (cmd 1). The result channel carries flash writes, flash
// read requests and link replies; last_of_run marks the final result that
// one input transaction causes.
// Each accepted transaction updates the protocol state and registers a run
// of zero to five results in the run register. The first result of a run
// moves from the run register into the output register, and the run then
// leaves at one result per cycle while the receiver takes them. The output
// register and the run register let the next transaction be taken while
// the previous run's last result still waits.
// When the receiver stalls, the current result holds and input stops once
// the run register is full. Reset clears the protocol back to waiting for
// the start token and drops any pending results.
// ----------------------------------------------------------------------------
module amd_flash_byte_programmer_top (
  input  logic      clk,
  input  logic      rst,
  afbp_in_if.sink   item,
  afbp_out_if.source result
);
  import afbp_pkg::*;

  run_desc_t desc;
  logic      take;
  logic      accept;

  assign item.ready = take;
  assign accept     = item.valid && take;

  afbp_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .accept     (accept),
    .cmd        (item.cmd),
    .link_word  (item.link_word),
    .flash_byte (item.flash_byte),
    .desc       (desc)
  );

  afbp_emit u_emit (
    .clk       (clk),
    .rst       (rst),
    .desc_load (accept && desc.kind != RUN_NONE),
    .desc_in   (desc),
    .take      (take),
    .result    (result)
  );

endmodule

// File: src/afbp_ctrl.sv
// ----------------------------------------------------------------------------
// afbp_ctrl
// Protocol state and data polling decision for each accepted transaction.
// ----------------------------------------------------------------------------
module afbp_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                accept,
  input  logic                cmd,
  input  logic [31:0]         link_word,
  input  logic [7:0]          flash_byte,
  output afbp_pkg::run_desc_t desc
);
  import afbp_pkg::*;

  phase_t      phase, phase_next;
  logic [31:0] flash_base, flash_base_next;
  logic [31:0] write_address, write_address_next;
  logic [31:0] words_left, words_left_next;
  logic [31:0] word_shift, word_shift_next;
  logic [1:0]  byte_index, byte_index_next;
  logic        recheck_pending, recheck_pending_next;
  logic        poll_pass;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase           <= PH_WAIT_START;
      flash_base      <= '0;
      write_address   <= '0;
      words_left      <= '0;
      word_shift      <= '0;
      byte_index      <= '0;
      recheck_pending <= 1'b0;
    end else begin
      phase           <= phase_next;
      flash_base      <= flash_base_next;
      write_address   <= write_address_next;
      words_left      <= words_left_next;
      word_shift      <= word_shift_next;
      byte_index      <= byte_index_next;
      recheck_pending <= recheck_pending_next;
    end
  end

  assign poll_pass = (flash_byte[7] == word_shift[7]);

  always_comb begin
    phase_next           = phase;
    flash_base_next      = flash_base;
    write_address_next   = write_address;
    words_left_next      = words_left;
    word_shift_next      = word_shift;
    byte_index_next      = byte_index;
    recheck_pending_next = recheck_pending;
    desc.kind            = RUN_NONE;
    desc.base            = flash_base;
    desc.addr            = write_address;
    desc.data            = word_shift[7:0];
    if (accept) begin
      if (phase == PH_POLL) begin
        if (cmd) begin
          if (poll_pass) begin
            recheck_pending_next = 1'b0;
            write_address_next   = write_address + 32'd1;
            word_shift_next      = {8'd0, word_shift[31:8]};
            if (byte_index == LAST_BYTE) begin
              byte_index_next = '0;
              words_left_next = words_left - 32'd1;
              if (words_left == 32'd1) begin
                desc.kind  = RUN_FIN;
                phase_next = PH_HALT;
              end else begin
                phase_next = PH_WAIT_DATA;
              end
            end else begin
              byte_index_next = byte_index + 2'd1;
              desc.kind       = RUN_PROGRAM;
              desc.addr       = write_address + 32'd1;
              desc.data       = word_shift[15:8];
            end
          end else if (recheck_pending) begin
            desc.kind            = RUN_FAIL;
            recheck_pending_next = 1'b0;
            phase_next           = PH_HALT;
          end else begin
            if (flash_byte[5]) begin
              recheck_pending_next = 1'b1;
            end
            desc.kind = RUN_READ;
          end
        end
      end else if (!cmd) begin
        case (phase)
          PH_WAIT_START: begin
            if (link_word == TOK_START) begin
              phase_next = PH_GET_BASE;
            end
          end
          PH_GET_BASE: begin
            flash_base_next = link_word;
            phase_next      = PH_GET_ADDR;
          end
          PH_GET_ADDR: begin
            write_address_next = link_word;
            phase_next         = PH_GET_LEN;
          end
          PH_GET_LEN: begin
            words_left_next = link_word;
            if (link_word == 32'd0) begin
              desc.kind  = RUN_ACK_FIN;
              phase_next = PH_HALT;
            end else begin
              desc.kind  = RUN_ACK;
              phase_next = PH_WAIT_DATA;
            end
          end
          PH_WAIT_DATA: begin
            word_shift_next      = link_word;
            byte_index_next      = '0;
            recheck_pending_next = 1'b0;
            desc.kind            = RUN_PROGRAM;
            desc.data            = link_word[7:0];
            phase_next           = PH_POLL;
          end
          default: begin
            phase_next = PH_HALT;
          end
        endcase
      end
    end
  end

  a_halt_sticky: assert property (@(posedge clk) disable iff (rst)
    phase == PH_HALT |=> phase == PH_HALT)
    else $error("engine left the halted phase");

  a_recheck_only_polling: assert property (@(posedge clk) disable iff (rst)
    recheck_pending |-> phase == PH_POLL)
    else $error("recheck pending outside polling");

  a_zero_count_halts: assert property (@(posedge clk) disable iff (rst)
    accept && !cmd && phase == PH_GET_LEN && link_word == 32'd0 |=> phase == PH_HALT)
    else $error("zero word count did not halt the engine");

endmodule

// File: src/afbp_emit.sv
// ----------------------------------------------------------------------------
// afbp_emit
// Holds one run of results and hands them out one per cycle through an
// output register while the receiver takes them.
// ----------------------------------------------------------------------------
module afbp_emit (
  input  logic                clk,
  input  logic                rst,
  input  logic                desc_load,
  input  afbp_pkg::run_desc_t desc_in,
  output logic                take,
  afbp_out_if.source          result
);
  import afbp_pkg::*;

  run_desc_t   desc;
  logic        desc_valid;
  logic [2:0]  step;
  logic        load;
  logic        step_last;
  logic [1:0]  r_kind;
  logic [31:0] r_addr;
  logic [31:0] r_data;
  logic [31:0] unlock1_addr;
  logic [31:0] unlock2_addr;

  logic        out_valid;
  logic [1:0]  op_kind;
  logic [31:0] bus_address;
  logic [31:0] bus_data;
  logic        last_of_run;

  assign unlock1_addr = desc.base + OFS_UNLOCK1;
  assign unlock2_addr = desc.base + OFS_UNLOCK2;
  assign load         = desc_valid && (!out_valid || result.ready);
  assign take         = !desc_valid || (load && step_last);

  always_comb begin
    r_kind    = OP_SEND;
    r_addr    = '0;
    r_data    = '0;
    step_last = 1'b1;
    case (desc.kind)
      RUN_ACK: begin
        r_data = TOK_ACK;
      end
      RUN_ACK_FIN: begin
        step_last = (step == 3'd1);
        r_data    = (step == 3'd0) ? TOK_ACK : TOK_FIN;
      end
      RUN_FIN: begin
        r_data = TOK_FIN;
      end
      RUN_READ: begin
        r_kind = OP_READ;
        r_addr = desc.addr;
      end
      RUN_FAIL: begin
        step_last = (step == 3'd1);
        if (step == 3'd0) begin
          r_kind = OP_WRITE;
          r_addr = unlock1_addr;
          r_data = {24'd0, CMD_RESET};
        end else begin
          r_data = TOK_NACK;
        end
      end
      RUN_PROGRAM: begin
        step_last = (step == 3'd4);
        r_kind    = OP_WRITE;
        case (step)
          3'd0: begin
            r_addr = unlock1_addr;
            r_data = {24'd0, CMD_UNLOCK1};
          end
          3'd1: begin
            r_addr = unlock2_addr;
            r_data = {24'd0, CMD_UNLOCK2};
          end
          3'd2: begin
            r_addr = unlock1_addr;
            r_data = {24'd0, CMD_PROGRAM};
          end
          3'd3: begin
            r_addr = desc.addr;
            r_data = {24'd0, desc.data};
          end
          default: begin
            r_kind = OP_READ;
            r_addr = desc.addr;
          end
        endcase
      end
      default: begin
        step_last = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      desc_valid <= 1'b0;
      step       <= '0;
      out_valid  <= 1'b0;
    end else begin
      if (take) begin
        desc_valid <= desc_load;
        step       <= '0;
      end else if (load) begin
        step <= step + 3'd1;
      end
      if (load) begin
        out_valid <= 1'b1;
      end else if (result.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      desc <= desc_in;
    end
    if (load) begin
      op_kind     <= r_kind;
      bus_address <= r_addr;
      bus_data    <= r_data;
      last_of_run <= step_last;
    end
  end

  assign result.valid       = out_valid;
  assign result.op_kind     = op_kind;
  assign result.bus_address = bus_address;
  assign result.bus_data    = bus_data;
  assign result.last_of_run = last_of_run;

  a_no_empty_run: assert property (@(posedge clk) disable iff (rst)
    desc_valid |-> desc.kind != RUN_NONE)
    else $error("empty run held for output");

  a_step_range: assert property (@(posedge clk) disable iff (rst)
    step <= 3'd4)
    else $error("run step out of range");

  a_run_closes: assert property (@(posedge clk) disable iff (rst)
    load && step_last |=> step == 3'd0)
    else $error("run did not restart after its final result");

endmodule

// File: tb/afbp_checker.sv
// ----------------------------------------------------------------------------
// afbp_checker
// Watches both channels of the flash byte programmer, predicts every bus
// operation and link reply from the accepted input transactions, and
// compares each result transaction against the oldest prediction.
// ----------------------------------------------------------------------------
module afbp_checker (
  input  logic clk,
  input  logic rst,
  afbp_in_if   item,
  afbp_out_if  result,
  output int   errors,
  output int   outstanding
);
  timeunit 1ns;
  timeprecision 1ps;

  import afbp_pkg::*;

  typedef struct packed {
    logic [1:0]  kind;
    logic [31:0] addr;
    logic [31:0] data;
    logic        last;
  } bus_op_t;

  bus_op_t     bus_ops_due[$];
  bus_op_t     run_ops[$];

  phase_t      phase;
  logic [31:0] flash_base;
  logic [31:0] write_addr;
  logic [31:0] words_left;
  logic [31:0] word_shift;
  logic [1:0]  byte_idx;
  logic        recheck;

  function automatic void emit(logic [1:0] kind, logic [31:0] addr, logic [31:0] data);
    bus_op_t op;
    op.kind = kind;
    op.addr = addr;
    op.data = data;
    op.last = 1'b0;
    run_ops.push_back(op);
  endfunction

  function automatic void program_byte();
    emit(OP_WRITE, flash_base + OFS_UNLOCK1, {24'd0, CMD_UNLOCK1});
    emit(OP_WRITE, flash_base + OFS_UNLOCK2, {24'd0, CMD_UNLOCK2});
    emit(OP_WRITE, flash_base + OFS_UNLOCK1, {24'd0, CMD_PROGRAM});
    emit(OP_WRITE, write_addr, {24'd0, word_shift[7:0]});
    emit(OP_READ, write_addr, 32'd0);
    recheck = 1'b0;
  endfunction

  task automatic predict_bus_ops(input logic cmd, input logic [31:0] word, input logic [7:0] rd);
    logic [7:0] dat;
    run_ops.delete();
    dat = word_shift[7:0];
    if (phase == PH_POLL) begin
      if (cmd) begin
        if (rd[7] == dat[7]) begin
          recheck = 1'b0;
          write_addr = write_addr + 32'd1;
          word_shift = word_shift >> 8;
          if (byte_idx == LAST_BYTE) begin
            byte_idx = 2'd0;
            words_left = words_left - 32'd1;
            if (words_left == 32'd0) begin
              emit(OP_SEND, 32'd0, TOK_FIN);
              phase = PH_HALT;
            end else begin
              phase = PH_WAIT_DATA;
            end
          end else begin
            byte_idx = byte_idx + 2'd1;
            program_byte();
          end
        end else if (recheck) begin
          emit(OP_WRITE, flash_base + OFS_UNLOCK1, {24'd0, CMD_RESET});
          emit(OP_SEND, 32'd0, TOK_NACK);
          recheck = 1'b0;
          phase = PH_HALT;
        end else begin
          if (rd[5]) recheck = 1'b1;
          emit(OP_READ, write_addr, 32'd0);
        end
      end
    end else if (!cmd) begin
      case (phase)
        PH_WAIT_START: begin
          if (word == TOK_START) phase = PH_GET_BASE;
        end
        PH_GET_BASE: begin
          flash_base = word;
          phase = PH_GET_ADDR;
        end
        PH_GET_ADDR: begin
          write_addr = word;
          phase = PH_GET_LEN;
        end
        PH_GET_LEN: begin
          words_left = word;
          emit(OP_SEND, 32'd0, TOK_ACK);
          if (word == 32'd0) begin
            emit(OP_SEND, 32'd0, TOK_FIN);
            phase = PH_HALT;
          end else begin
            phase = PH_WAIT_DATA;
          end
        end
        PH_WAIT_DATA: begin
          word_shift = word;
          byte_idx = 2'd0;
          program_byte();
          phase = PH_POLL;
        end
        default: begin
          phase = PH_HALT;
        end
      endcase
    end
    if (run_ops.size() > 0) run_ops[run_ops.size() - 1].last = 1'b1;
    foreach (run_ops[i]) bus_ops_due.push_back(run_ops[i]);
  endtask

  always @(posedge clk) begin
    bus_op_t got;
    bus_op_t exp;
    if (rst) begin
      phase = PH_WAIT_START;
      flash_base = '0;
      write_addr = '0;
      words_left = '0;
      word_shift = '0;
      byte_idx = '0;
      recheck = 1'b0;
      bus_ops_due.delete();
    end else begin
      if (item.valid && item.ready) begin
        predict_bus_ops(item.cmd, item.link_word, item.flash_byte);
      end
      if (result.valid && result.ready) begin
        got = {result.op_kind, result.bus_address, result.bus_data, result.last_of_run};
        if (bus_ops_due.size() == 0) begin
          errors++;
          if (errors <= 10) begin
            $display("unexpected transaction: kind %0d addr %h data %h last %0d",
                     got.kind, got.addr, got.data, got.last);
          end
        end else begin
          exp = bus_ops_due.pop_front();
          if (got !== exp) begin
            errors++;
            if (errors <= 10) begin
              $display("mismatch: expected kind %0d addr %h data %h last %0d, got kind %0d addr %h data %h last %0d",
                       exp.kind, exp.addr, exp.data, exp.last,
                       got.kind, got.addr, got.data, got.last);
            end
          end
        end
      end
    end
    outstanding = bus_ops_due.size();
  end

  initial begin
    errors = 0;
    outstanding = 0;
  end
endmodule

// File: tb/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Drives one programming session into the flash byte programmer: noise before
// the start token, the session header, data words answered by polling bytes
// (busy, pass, recheck), and a fin or Nack ending followed by halted traffic.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import afbp_pkg::*;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic hold;
  int   burst_left = 0;
  int   n_sent = 0;
  int   mismatches;
  int   ops_pending;

  afbp_in_if  item ();
  afbp_out_if result ();

  amd_flash_byte_programmer_top dut (
    .clk    (clk),
    .rst    (rst),
    .item   (item),
    .result (result)
  );

  afbp_checker checker_i (
    .clk         (clk),
    .rst         (rst),
    .item        (item),
    .result      (result),
    .errors      (mismatches),
    .outstanding (ops_pending)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  task automatic push_item(input logic cmd, input logic [31:0] word, input logic [7:0] rd);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 2) == 0) ? $urandom_range(1, 8) : 0;
      burst_left = $urandom_range(1, 30);
      if (gap > 0) begin
        item.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    item.valid <= 1'b1;
    item.cmd <= cmd;
    item.link_word <= word;
    item.flash_byte <= rd;
    @(posedge clk);
    while (!item.ready) @(posedge clk);
    n_sent++;
  endtask

  function automatic logic [7:0] read_byte(input logic dq7, input logic dq5);
    logic [7:0] b;
    b = 8'($urandom);
    b[7] = dq7;
    b[5] = dq5;
    return b;
  endfunction

  task automatic program_word(input logic [31:0] w, input int fail_at);
    logic d7;
    push_item(1'b0, w, 8'($urandom));
    for (int i = 0; i < 4; i++) begin
      d7 = w[8 * i + 7];
      if ($urandom_range(0, 9) == 0) push_item(1'b0, $urandom, 8'($urandom));
      if ($urandom_range(0, 2) == 0) begin
        repeat ($urandom_range(1, 3)) push_item(1'b1, $urandom, read_byte(!d7, 1'b0));
      end
      if (i == fail_at) begin
        push_item(1'b1, $urandom, read_byte(!d7, 1'b1));
        push_item(1'b1, $urandom, read_byte(!d7, 1'($urandom)));
        return;
      end
      if ($urandom_range(0, 4) == 0) push_item(1'b1, $urandom, read_byte(!d7, 1'b1));
      push_item(1'b1, $urandom, read_byte(d7, 1'($urandom)));
    end
    if ($urandom_range(0, 7) == 0) push_item(1'b1, $urandom, 8'($urandom));
  endtask

  initial begin
    int          n_words;
    bit          nack_end;
    logic [31:0] w;
    item.valid <= 1'b0;
    item.cmd <= 1'b0;
    item.link_word <= '0;
    item.flash_byte <= '0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    n_words = $urandom_range(55, 65);
    nack_end = 1'($urandom);

    push_item(1'b1, 32'd0, 8'hFF);
    push_item(1'b0, 32'hFFFF_FFFF, 8'h00);
    push_item(1'b0, 32'h0000_0000, 8'hFF);
    push_item(1'b1, 32'hFFFF_FFFF, 8'h00);
    push_item(1'b0, TOK_START, 8'h00);
    push_item(1'b1, 32'd0, 8'hFF);
    push_item(1'b0, 32'hFFFF_FD00, 8'h00);
    push_item(1'b0, 32'hFFFF_FFFE, 8'h00);
    push_item(1'b0, n_words + 2, 8'h00);

    push_item(1'b0, 32'hFFFF_FFFF, 8'h00);
    push_item(1'b1, 32'd0, 8'h00);
    push_item(1'b1, 32'd0, 8'hFF);
    push_item(1'b1, 32'd0, 8'h7F);
    push_item(1'b1, 32'd0, 8'h80);
    push_item(1'b0, TOK_START, 8'h00);
    push_item(1'b1, 32'd0, 8'hFF);
    push_item(1'b1, 32'd0, 8'hDF);
    push_item(1'b1, 32'd0, 8'hFF);
    program_word(32'h0000_0000, 4);

    for (int k = 0; k < n_words; k++) begin
      case ($urandom_range(0, 9))
        0: w = 32'h0000_0000;
        1: w = 32'hFFFF_FFFF;
        2: w = 32'h8080_8080;
        default: w = $urandom;
      endcase
      program_word(w, (nack_end && k == n_words - 1) ? $urandom_range(0, 3) : 4);
    end

    push_item(1'b0, TOK_START, 8'h00);
    repeat (8) push_item(1'($urandom), $urandom, 8'($urandom));
    item.valid <= 1'b0;

    repeat (2) @(posedge clk);
    wait (ops_pending == 0);
    repeat (30) @(posedge clk);
    if (mismatches == 0 && ops_pending == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  initial begin
    int stall_mode;
    int mode_cycles;
    int cnt;
    result.ready <= 1'b0;
    stall_mode = 0;
    mode_cycles = 0;
    cnt = 0;
    forever begin
      @(posedge clk);
      if (mode_cycles == 0) begin
        stall_mode = $urandom_range(0, 2);
        mode_cycles = $urandom_range(20, 150);
      end
      mode_cycles--;
      cnt++;
      case (stall_mode)
        0: result.ready <= !hold;
        1: result.ready <= !hold && 1'($urandom);
        default: result.ready <= !hold && (cnt % 4 == 0);
      endcase
    end
  end

  initial begin
    hold <= 1'b0;
    wait (n_sent >= 150);
    @(posedge clk);
    hold <= 1'b1;
    repeat (400) @(posedge clk);
    hold <= 1'b0;
  end

  initial begin
    #2000000;
    $display("simulation failed");
    $finish;
  end
endmodule
